FILE: sv/hsv_roi_dominant_color_classifier_macros.svh
// Assertion macros used by the checker file of the dominant color classifier.
`ifndef HSV_ROI_DOMINANT_COLOR_CLASSIFIER_MACROS_SVH
`define HSV_ROI_DOMINANT_COLOR_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HRDC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hrdc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HRDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hrdc assertion failed");

`endif

FILE: sv/hrdc_pkg.sv
// Types, constants and register map of the dominant color classifier.
`default_nettype none
package hrdc_pkg;

	localparam int TALLY_W = 22;
	localparam int PROD_W = 32;
	localparam int RATIO_W = 10;
	localparam int NUM_CFG = 8;
	localparam int CFG_IDX_W = 3;
	localparam int PADDR_W = CFG_IDX_W + 2;
	localparam int PDATA_W = 32;

	localparam int unsigned MAX_FRAME_PIXELS_DEF = 32'd2097152;

	typedef logic [TALLY_W-1:0] tally_t;
	typedef logic [PROD_W-1:0] prod_t;

	localparam tally_t TALLY_FULL = 22'h3FFFFF;
	localparam logic [7:0] HUE_TOP = 8'd180;
	localparam logic [RATIO_W-1:0] RATIO_SCALE = 10'd1000;

	typedef enum logic [1:0] {
		COLOR_OFF    = 2'd0,
		COLOR_RED    = 2'd1,
		COLOR_YELLOW = 2'd2,
		COLOR_GREEN  = 2'd3
	} color_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RED_HUE_MAX    = 3'd0,
		REG_RED_WRAP_MIN   = 3'd1,
		REG_YELLOW_HUE_MIN = 3'd2,
		REG_YG_SPLIT       = 3'd3,
		REG_GREEN_HUE_MAX  = 3'd4,
		REG_SAT_MIN        = 3'd5,
		REG_VAL_MIN        = 3'd6,
		REG_MIN_RATIO      = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]         red_hue_max;
		logic [7:0]         red_hue_wrap_min;
		logic [7:0]         yellow_hue_min;
		logic [7:0]         yellow_green_split;
		logic [7:0]         green_hue_max;
		logic [7:0]         sat_min;
		logic [7:0]         val_min;
		logic [RATIO_W-1:0] min_ratio_permille;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		red_hue_max:        8'd10,
		red_hue_wrap_min:   8'd170,
		yellow_hue_min:     8'd15,
		yellow_green_split: 8'd40,
		green_hue_max:      8'd90,
		sat_min:            8'd80,
		val_min:            8'd80,
		min_ratio_permille: 10'd80
	};

endpackage
`default_nettype wire

FILE: sv/hrdc_pix_if.sv
// Pixel channel: valid/ready handshake carrying one HSV pixel word.
`default_nettype none
interface hrdc_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] hue;
	logic [7:0] saturation;
	logic [7:0] brightness;
	logic       in_region;
	logic       frame_end;

	modport source (output valid, hue, saturation, brightness, in_region, frame_end,
		input ready);
	modport sink (input valid, hue, saturation, brightness, in_region, frame_end,
		output ready);
endinterface
`default_nettype wire

FILE: sv/hrdc_res_if.sv
// Result channel: valid/ready handshake carrying one frame summary word.
`default_nettype none
interface hrdc_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  color;
	logic [21:0] red_pixels;
	logic [21:0] yellow_pixels;
	logic [21:0] green_pixels;
	logic [21:0] region_pixels;

	modport source (output valid, color, red_pixels, yellow_pixels, green_pixels,
		region_pixels, input ready);
	modport sink (input valid, color, red_pixels, yellow_pixels, green_pixels,
		region_pixels, output ready);
endinterface
`default_nettype wire

FILE: sv/hsv_roi_dominant_color_classifier.sv
// A frame-end pixel passes the input, totals, product and output registers in turn.
// Throughput: one pixel per cycle except during a stall; the input register, the tally
// update, a product stage and a compare stage run concurrently.
// A result word waiting at the output stalls the pipe only when it is full.
// Reset (arst_n low, asynchronous) clears all valid flags and tallies and loads the
// register reset values; no clearing pass is needed.
`default_nettype none
module hsv_roi_dominant_color_classifier
	import hrdc_pkg::*;
#(
	parameter int unsigned MAX_FRAME_PIXELS = MAX_FRAME_PIXELS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	hrdc_pix_if.sink                pix,
	hrdc_res_if.source              res,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	localparam tally_t TALLY_CAP = (MAX_FRAME_PIXELS < 32'(TALLY_FULL)) ?
		TALLY_W'(MAX_FRAME_PIXELS) : TALLY_FULL;

	cfg_t cfg;

	hrdc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	function automatic tally_t bump(tally_t t, logic hit);
		return (hit && (t < TALLY_CAP)) ? TALLY_W'(t + 1'b1) : t;
	endfunction

	// stage 1: input register
	logic       valid_s1;
	logic [7:0] hue_s1, sat_s1, bri_s1;
	logic       region_s1, last_s1;

	// running tallies
	tally_t red_q, yel_q, grn_q, reg_q;

	// stage 2: frame totals
	logic   valid_s2;
	tally_t red_s2, yel_s2, grn_s2, reg_s2;

	// stage 3: products and candidate color
	logic   valid_s3;
	prod_t  pmax_s3, pthr_s3;
	color_t cand_s3;
	logic   nzero_s3;
	tally_t red_s3, yel_s3, grn_s3, reg_s3;

	// output register
	logic   out_valid_q;
	color_t color_q;
	tally_t red_out_q, yel_out_q, grn_out_q, reg_out_q;

	logic out_free, s3_free, s2_free, s1_leave, s1_free, fire_s1;

	assign out_free = !out_valid_q || res.ready;
	assign s3_free  = !valid_s3 || out_free;
	assign s2_free  = !valid_s2 || s3_free;
	// a pixel without the frame mark drains into the tallies at once
	assign s1_leave = !last_s1 || s2_free;
	assign s1_free  = !valid_s1 || s1_leave;
	assign fire_s1  = valid_s1 && s1_leave;
	assign pix.ready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.valid && s1_free) begin
			hue_s1    <= pix.hue;
			sat_s1    <= pix.saturation;
			bri_s1    <= pix.brightness;
			region_s1 <= pix.in_region;
			last_s1   <= pix.frame_end;
		end
	end

	// band tests
	logic   sv_ok, red_hit, yel_hit, grn_hit;
	tally_t red_nx, yel_nx, grn_nx, reg_nx;

	always_comb begin
		sv_ok   = region_s1 && (sat_s1 >= cfg.sat_min) && (bri_s1 >= cfg.val_min);
		red_hit = sv_ok && ((hue_s1 <= cfg.red_hue_max) ||
			((hue_s1 >= cfg.red_hue_wrap_min) && (hue_s1 <= HUE_TOP)));
		yel_hit = sv_ok && (hue_s1 >= cfg.yellow_hue_min) &&
			(hue_s1 <= cfg.yellow_green_split);
		grn_hit = sv_ok && (hue_s1 >= cfg.yellow_green_split) &&
			(hue_s1 <= cfg.green_hue_max);
		red_nx  = bump(red_q, red_hit);
		yel_nx  = bump(yel_q, yel_hit);
		grn_nx  = bump(grn_q, grn_hit);
		reg_nx  = bump(reg_q, region_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q <= '0;
			yel_q <= '0;
			grn_q <= '0;
			reg_q <= '0;
		end else if (fire_s1) begin
			if (last_s1) begin
				red_q <= '0;
				yel_q <= '0;
				grn_q <= '0;
				reg_q <= '0;
			end else begin
				red_q <= red_nx;
				yel_q <= yel_nx;
				grn_q <= grn_nx;
				reg_q <= reg_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= fire_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && fire_s1 && last_s1) begin
			red_s2 <= red_nx;
			yel_s2 <= yel_nx;
			grn_s2 <= grn_nx;
			reg_s2 <= reg_nx;
		end
	end

	// largest band and tie order: red, then yellow, then green
	tally_t mx_s2;
	color_t cand_s2;

	always_comb begin
		mx_s2 = red_s2;
		if (yel_s2 > mx_s2) begin
			mx_s2 = yel_s2;
		end
		if (grn_s2 > mx_s2) begin
			mx_s2 = grn_s2;
		end
		if ((red_s2 >= yel_s2) && (red_s2 >= grn_s2)) begin
			cand_s2 = COLOR_RED;
		end else if (yel_s2 >= grn_s2) begin
			cand_s2 = COLOR_YELLOW;
		end else begin
			cand_s2 = COLOR_GREEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_free) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free && valid_s2) begin
			pmax_s3  <= PROD_W'(mx_s2) * PROD_W'(RATIO_SCALE);
			pthr_s3  <= PROD_W'(cfg.min_ratio_permille) * PROD_W'(reg_s2);
			cand_s3  <= cand_s2;
			nzero_s3 <= (reg_s2 == '0);
			red_s3   <= red_s2;
			yel_s3   <= yel_s2;
			grn_s3   <= grn_s2;
			reg_s3   <= reg_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s3) begin
			color_q   <= (nzero_s3 || (pmax_s3 < pthr_s3)) ? COLOR_OFF : cand_s3;
			red_out_q <= red_s3;
			yel_out_q <= yel_s3;
			grn_out_q <= grn_s3;
			reg_out_q <= reg_s3;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.color         = color_q;
	assign res.red_pixels    = red_out_q;
	assign res.yellow_pixels = yel_out_q;
	assign res.green_pixels  = grn_out_q;
	assign res.region_pixels = reg_out_q;

endmodule
`default_nettype wire

FILE: sv/hrdc_cfg_regs.sv
// APB configuration registers of the dominant color classifier.
`default_nettype none
module hrdc_cfg_regs
	import hrdc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	cfg_t     cfg_q;
	cfg_reg_t idx;
	logic     wr_en;

	assign idx    = cfg_reg_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_RED_HUE_MAX:    cfg_q.red_hue_max        <= pwdata[7:0];
				REG_RED_WRAP_MIN:   cfg_q.red_hue_wrap_min   <= pwdata[7:0];
				REG_YELLOW_HUE_MIN: cfg_q.yellow_hue_min     <= pwdata[7:0];
				REG_YG_SPLIT:       cfg_q.yellow_green_split <= pwdata[7:0];
				REG_GREEN_HUE_MAX:  cfg_q.green_hue_max      <= pwdata[7:0];
				REG_SAT_MIN:        cfg_q.sat_min            <= pwdata[7:0];
				REG_VAL_MIN:        cfg_q.val_min            <= pwdata[7:0];
				REG_MIN_RATIO:      cfg_q.min_ratio_permille <= pwdata[RATIO_W-1:0];
				default:            cfg_q                    <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_RED_HUE_MAX:    prdata = PDATA_W'(cfg_q.red_hue_max);
			REG_RED_WRAP_MIN:   prdata = PDATA_W'(cfg_q.red_hue_wrap_min);
			REG_YELLOW_HUE_MIN: prdata = PDATA_W'(cfg_q.yellow_hue_min);
			REG_YG_SPLIT:       prdata = PDATA_W'(cfg_q.yellow_green_split);
			REG_GREEN_HUE_MAX:  prdata = PDATA_W'(cfg_q.green_hue_max);
			REG_SAT_MIN:        prdata = PDATA_W'(cfg_q.sat_min);
			REG_VAL_MIN:        prdata = PDATA_W'(cfg_q.val_min);
			REG_MIN_RATIO:      prdata = PDATA_W'(cfg_q.min_ratio_permille);
			default:            prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

FILE: sv/hrdc_checker.sv
// Port-level checker of the dominant color classifier and its bind.
`default_nettype none
`include "hsv_roi_dominant_color_classifier_macros.svh"
module hrdc_checker
	import hrdc_pkg::*;
(
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         out_valid,
	input wire logic         out_ready,
	input wire logic [1:0]   color,
	input wire logic [21:0]  red_pixels,
	input wire logic [21:0]  yellow_pixels,
	input wire logic [21:0]  green_pixels,
	input wire logic [21:0]  region_pixels
);

	// hold a stalled result word
	`HRDC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(color) && $stable(region_pixels))

	// an empty region never names a color
	`HRDC_ASSERT_NOW(a_empty_off, clk, arst_n, out_valid && (region_pixels == '0),
		color == COLOR_OFF)

	// band counts never exceed the region count
	`HRDC_ASSERT_NOW(a_band_le_region, clk, arst_n, out_valid,
		(red_pixels <= region_pixels) && (yellow_pixels <= region_pixels) &&
		(green_pixels <= region_pixels))

	// red wins ties
	`HRDC_ASSERT_NOW(a_red_max, clk, arst_n, out_valid && (color == COLOR_RED),
		(red_pixels >= yellow_pixels) && (red_pixels >= green_pixels))

	// green only when strictly largest
	`HRDC_ASSERT_NOW(a_green_max, clk, arst_n, out_valid && (color == COLOR_GREEN),
		(green_pixels > red_pixels) && (green_pixels > yellow_pixels))

endmodule

bind hsv_roi_dominant_color_classifier hrdc_checker u_hrdc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (res.valid),
	.out_ready     (res.ready),
	.color         (res.color),
	.red_pixels    (res.red_pixels),
	.yellow_pixels (res.yellow_pixels),
	.green_pixels  (res.green_pixels),
	.region_pixels (res.region_pixels)
);
`default_nettype wire
